// ----- sv/apu_pkg.sv -----
// Package for the sound unit control core: register offsets, reset bytes, helpers.
// No dependencies.
package apu_pkg;
   localparam int unsigned NumRegs = 31;
   localparam logic [4:0] OFF_SW = 5'h00, OFF_L1 = 5'h01, OFF_E1 = 5'h02, OFF_F1L = 5'h03,
      OFF_F1H = 5'h04, OFF_L2 = 5'h06, OFF_E2 = 5'h07, OFF_F2L = 5'h08, OFF_F2H = 5'h09,
      OFF_LN = 5'h10, OFF_EN = 5'h11, OFF_PN = 5'h12, OFF_CN = 5'h13, OFF_POWER = 5'h16;
   localparam logic [1:0] FUNC_WRITE = 2'd0, FUNC_READ = 2'd1, FUNC_FRAME = 2'd2,
      FUNC_NOISE = 2'd3;
   localparam logic [7:0] DAC_MASK = 8'hF8;
   localparam logic [11:0] FREQ_MAX = 12'd2047;
   localparam logic [14:0] LFSR_SEED = 15'h7FFF;

   function automatic logic [7:0] reset_byte(input logic [4:0] i);
      logic [7:0] r;
      case (i)
         5'd0: r = 8'h80; 5'd1: r = 8'hBF; 5'd2: r = 8'hF3; 5'd4: r = 8'hBF;
         5'd6: r = 8'h3F; 5'd7: r = 8'h00; 5'd9: r = 8'hBF; 5'd10: r = 8'h7F;
         5'd12: r = 8'h9F; 5'd14: r = 8'hBF; 5'd17: r = 8'h00; 5'd18: r = 8'h00;
         5'd19: r = 8'hBF; 5'd20: r = 8'h77; 5'd21: r = 8'hF3; 5'd22: r = 8'hF1;
         default: r = 8'hFF;
      endcase
      return r;
   endfunction

   // shadow +/- (shadow >> shift), 12-bit wrap
   function automatic logic [11:0] sweep_calc(input logic [11:0] sh, input logic neg,
                                              input logic [2:0] shift);
      logic [11:0] d;
      d = sh >> shift;
      return neg ? sh - d : sh + d;
   endfunction
endpackage

// ----- sv/apu_channel_control.sv -----
// Sound unit control core: two square channels (one swept) and a noise channel.
// Depends on apu_pkg.
//
// Usage: one request per cycle on req_ while req_ready is high (func, reg_offset, write_data):
//   write, read, frame sequencer tick, or noise LFSR shift.
// Every request yields one response on rsp_ carrying read data (reads only),
// power and channel flags, envelope levels, swept square-one frequency and
// the noise output bit, all as they stand after the request.
// Latency: state updates in the accept cycle; the response register shows
// the result the next cycle. Throughput: one request per clock; the only
// limit is the single response register, which refills in the same cycle
// it is drained.
// Receiver stall: the response register holds; req_ready drops while it is
// full and not being taken, so no request is lost.
// Reset (synchronous, active high): registers return to power-on bytes,
// all counters clear, master power is on, response register empties.
module apu_channel_control import apu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [4:0]  req_reg_offset,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_power_on,
   output logic        rsp_sq1_on,
   output logic        rsp_sq2_on,
   output logic        rsp_noise_on,
   output logic [3:0]  rsp_sq1_level,
   output logic [3:0]  rsp_sq2_level,
   output logic [3:0]  rsp_noise_level,
   output logic [10:0] rsp_sq1_period_code,
   output logic        rsp_noise_bit
);
   logic [7:0]  regs_ff [NumRegs];
   logic [7:0]  regs_in [NumRegs];
   logic [3:0]  vol_ff [3], vol_in [3];
   logic        up_ff [3], up_in [3];
   logic [2:0]  ep_ff [3], ep_in [3];
   logic        len_en_ff [3], len_en_in [3];
   logic [10:0] freq_ff [2], freq_in [2];
   logic [2:0]  sw_period_ff, sw_period_in, sw_shift_ff, sw_shift_in;
   logic        sw_neg_ff, sw_neg_in, nz_w7_ff, nz_w7_in;
   logic [6:0]  len_ff [3], len_in [3];
   logic [3:0]  env_ff [3], env_in [3];
   logic [3:0]  lvl_ff [3], lvl_in [3];
   logic        on_ff [3], on_in [3];
   logic [11:0] shadow_ff, shadow_in;
   logic [3:0]  swc_ff, swc_in;
   logic        swa_ff, swa_in;
   logic [14:0] lfsr_ff, lfsr_in;
   logic [2:0]  step_ff, step_in;
   logic        master_ff, master_in;
   logic        rsp_valid_ff;
   logic [7:0]  rd_ff, rd_in;

   logic accept;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      logic [4:0]  off;
      logic [7:0]  v;
      logic [11:0] nf;
      logic [3:0]  swc;
      logic [14:0] r;
      logic        x;
      logic [1:0]  ch;
      off = req_reg_offset;
      v   = req_write_data;
      regs_in = regs_ff; vol_in = vol_ff; up_in = up_ff; ep_in = ep_ff;
      len_en_in = len_en_ff; freq_in = freq_ff; sw_period_in = sw_period_ff;
      sw_shift_in = sw_shift_ff; sw_neg_in = sw_neg_ff; nz_w7_in = nz_w7_ff;
      len_in = len_ff; env_in = env_ff; lvl_in = lvl_ff; on_in = on_ff;
      shadow_in = shadow_ff; swc_in = swc_ff; swa_in = swa_ff; lfsr_in = lfsr_ff;
      step_in = step_ff; master_in = master_ff; rd_in = 8'h00;
      nf = 12'd0; swc = 4'd0; r = 15'd0; x = 1'b0; ch = 2'd0;
      case (req_func)
         FUNC_WRITE: begin
            if (off != 5'd31 && (master_ff || off == OFF_POWER)) begin
               regs_in[off] = v;
               case (off)
                  OFF_SW: begin
                     sw_period_in = v[6:4]; sw_neg_in = v[3]; sw_shift_in = v[2:0];
                  end
                  OFF_L1: len_in[0] = 7'd64 - {1'b0, v[5:0]};
                  OFF_L2: len_in[1] = 7'd64 - {1'b0, v[5:0]};
                  OFF_LN: len_in[2] = 7'd64 - {1'b0, v[5:0]};
                  OFF_E1, OFF_E2, OFF_EN: begin
                     ch = (off == OFF_E1) ? 2'd0 : (off == OFF_E2) ? 2'd1 : 2'd2;
                     vol_in[ch] = v[7:4]; up_in[ch] = v[3]; ep_in[ch] = v[2:0];
                     if ((v & DAC_MASK) == 8'h00) on_in[ch] = 1'b0;
                  end
                  OFF_F1L: freq_in[0][7:0] = v;
                  OFF_F2L: freq_in[1][7:0] = v;
                  OFF_PN: nz_w7_in = v[3];
                  OFF_F1H, OFF_F2H, OFF_CN: begin
                     ch = (off == OFF_F1H) ? 2'd0 : (off == OFF_F2H) ? 2'd1 : 2'd2;
                     if (ch != 2'd2) freq_in[ch[0]][10:8] = v[2:0];
                     len_en_in[ch] = v[6];
                     if (v[7]) begin
                        // trigger
                        on_in[ch] = (regs_ff[off - 5'd2] & DAC_MASK) != 8'h00;
                        if (len_ff[ch] == 7'd0) len_in[ch] = 7'd64;
                        env_in[ch] = (ep_ff[ch] != 3'd0) ? {1'b0, ep_ff[ch]} : 4'd8;
                        lvl_in[ch] = vol_ff[ch];
                        if (ch == 2'd0) begin
                           shadow_in = {1'b0, v[2:0], freq_ff[0][7:0]};
                           swc_in = (sw_period_ff != 3'd0) ? {1'b0, sw_period_ff} : 4'd8;
                           swa_in = (sw_period_ff != 3'd0) || (sw_shift_ff != 3'd0);
                           nf = sweep_calc(shadow_in, sw_neg_ff, sw_shift_ff);
                           if (sw_shift_ff != 3'd0 && nf > FREQ_MAX) on_in[0] = 1'b0;
                        end
                        if (ch == 2'd2) lfsr_in = LFSR_SEED;
                     end
                  end
                  OFF_POWER: begin
                     master_in = v[7];
                     if (!v[7]) begin
                        on_in[0] = 1'b0; on_in[1] = 1'b0; on_in[2] = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         FUNC_READ: begin
            if (off == OFF_POWER)
               rd_in = {master_ff, 3'b111, on_ff[2], 1'b0, on_ff[1], on_ff[0]};
            else if (off == 5'd31) rd_in = 8'hFF;
            else rd_in = regs_ff[off];
         end
         FUNC_FRAME: begin
            if (!step_ff[0]) begin
               for (int i = 0; i < 3; i++) begin
                  if (len_en_ff[i] && len_ff[i] != 7'd0) begin
                     len_in[i] = len_ff[i] - 7'd1;
                     if (len_ff[i] == 7'd1) on_in[i] = 1'b0;
                  end
               end
            end
            if ((step_ff == 3'd2 || step_ff == 3'd6) && swc_ff != 4'd0) begin
               swc = swc_ff - 4'd1;
               swc_in = swc;
               if (swc == 4'd0) begin
                  swc_in = (sw_period_ff != 3'd0) ? {1'b0, sw_period_ff} : 4'd8;
                  if (swa_ff && sw_period_ff != 3'd0) begin
                     nf = sweep_calc(shadow_ff, sw_neg_ff, sw_shift_ff);
                     if (nf > FREQ_MAX) on_in[0] = 1'b0;
                     else if (sw_shift_ff != 3'd0) begin
                        shadow_in = nf;
                        freq_in[0] = nf[10:0];
                        regs_in[3] = nf[7:0];
                        regs_in[4] = {regs_ff[4][7:3], nf[10:8]};
                        if (sweep_calc(nf, sw_neg_ff, sw_shift_ff) > FREQ_MAX)
                           on_in[0] = 1'b0;
                     end
                  end
               end
            end
            if (step_ff == 3'd7) begin
               for (int i = 0; i < 3; i++) begin
                  if (ep_ff[i] != 3'd0) begin
                     if (env_ff[i] <= 4'd1) begin
                        env_in[i] = {1'b0, ep_ff[i]};
                        if (up_ff[i] && lvl_ff[i] != 4'd15) lvl_in[i] = lvl_ff[i] + 4'd1;
                        else if (!up_ff[i] && lvl_ff[i] != 4'd0)
                           lvl_in[i] = lvl_ff[i] - 4'd1;
                     end else env_in[i] = env_ff[i] - 4'd1;
                  end
               end
            end
            step_in = step_ff + 3'd1;
         end
         default: begin
            x = lfsr_ff[0] ^ lfsr_ff[1];
            r = {x, lfsr_ff[14:1]};
            if (nz_w7_ff) r[6] = x;
            lfsr_in = r;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumRegs; i++) regs_ff[i] <= reset_byte(5'(i));
         for (int i = 0; i < 3; i++) begin
            vol_ff[i] <= '0; up_ff[i] <= 1'b0; ep_ff[i] <= '0; len_en_ff[i] <= 1'b0;
            len_ff[i] <= '0; env_ff[i] <= '0; lvl_ff[i] <= '0; on_ff[i] <= 1'b0;
         end
         freq_ff[0] <= '0; freq_ff[1] <= '0;
         sw_period_ff <= '0; sw_shift_ff <= '0; sw_neg_ff <= 1'b0; nz_w7_ff <= 1'b0;
         shadow_ff <= '0; swc_ff <= '0; swa_ff <= 1'b0; lfsr_ff <= '0;
         step_ff <= '0; master_ff <= 1'b1; rsp_valid_ff <= 1'b0; rd_ff <= '0;
      end else begin
         if (accept) begin
            regs_ff <= regs_in; vol_ff <= vol_in; up_ff <= up_in; ep_ff <= ep_in;
            len_en_ff <= len_en_in; freq_ff <= freq_in; sw_period_ff <= sw_period_in;
            sw_shift_ff <= sw_shift_in; sw_neg_ff <= sw_neg_in; nz_w7_ff <= nz_w7_in;
            len_ff <= len_in; env_ff <= env_in; lvl_ff <= lvl_in; on_ff <= on_in;
            shadow_ff <= shadow_in; swc_ff <= swc_in; swa_ff <= swa_in;
            lfsr_ff <= lfsr_in; step_ff <= step_in; master_ff <= master_in;
            rd_ff <= rd_in;
         end
         if (accept) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Status fields track live state, which only changes on accept, so they
   // stay stable while a response waits.
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_data       = rd_ff;
   assign rsp_power_on        = master_ff;
   assign rsp_sq1_on          = on_ff[0];
   assign rsp_sq2_on          = on_ff[1];
   assign rsp_noise_on        = on_ff[2];
   assign rsp_sq1_level       = lvl_ff[0];
   assign rsp_sq2_level       = lvl_ff[1];
   assign rsp_noise_level     = lvl_ff[2];
   assign rsp_sq1_period_code = freq_ff[0];
   assign rsp_noise_bit       = !lfsr_ff[0];
endmodule
